/* rtl/core/aer_frame_decoder_assert.svh */
// assertion macros shared by the frame decoder modules
`ifndef AER_FRAME_DECODER_ASSERT_SVH
`define AER_FRAME_DECODER_ASSERT_SVH

// same-cycle implication, disabled during reset
`define AER_ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("aer decoder: same-cycle check failed");

// next-cycle implication, disabled during reset
`define AER_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("aer decoder: next-cycle check failed");

`endif

/* rtl/core/aer_pkg.sv */
// shared types and constants for the aer frame decoder
package aer_pkg;

   localparam logic [3:0] HDR_LEN     = 4'd12;
   localparam logic [3:0] MAGIC_LEN   = 4'd4;
   localparam logic [3:0] DIGIT_LIMIT = 4'd10;

   localparam logic [2:0] ST_OK       = 3'd0;
   localparam logic [2:0] ST_SHORT    = 3'd1;
   localparam logic [2:0] ST_MAGIC    = 3'd2;
   localparam logic [2:0] ST_TRUNC    = 3'd3;
   localparam logic [2:0] ST_OVERFLOW = 3'd4;

   localparam logic [1:0] KIND_MAGIC = 2'd0;
   localparam logic [1:0] KIND_TIME  = 2'd1;
   localparam logic [1:0] KIND_DIGIT = 2'd2;

   localparam logic [1:0] FIELD_DELTA   = 2'd0;
   localparam logic [1:0] FIELD_ADDRESS = 2'd1;
   localparam logic [1:0] FIELD_VALUE   = 2'd2;

   localparam int QUEUE_DEPTH = 4;
   localparam int QUEUE_AW    = 2;

   // one classified request on its way to the back end
   typedef struct packed {
      logic [1:0] kind;
      logic [2:0] lane;
      logic       magic_bad;
      logic       hdr_short;
      logic [7:0] data;
      logic       eof;
   } tok_type;

   function automatic logic [7:0] magic_byte(input logic [1:0] idx);
      logic [7:0] b;
      case (idx)
         2'd0: b = 8'h41;
         2'd1: b = 8'h45;
         2'd2: b = 8'h52;
         default: b = 8'h31;
      endcase
      return b;
   endfunction

endpackage

/* rtl/core/aer_front.sv */
// front end: header tracking, magic check and request classification
module aer_front (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  logic [7:0]       req_data_byte,
   input  logic             req_end_of_frame,
   input  logic             queue_full,
   output logic             push_valid,
   output aer_pkg::tok_type push_tok
);
   import aer_pkg::*;

   logic [3:0] hdr_cnt_ff, hdr_cnt_in;
   logic       mism_ff, mism_in;
   logic [3:0] hdr_after;
   logic [3:0] lane_full;
   logic       in_header;
   logic       byte_bad;
   logic       accept;

   assign req_ready  = !queue_full;
   assign accept     = req_valid && !queue_full;
   assign push_valid = accept;

   always_comb begin
      in_header = hdr_cnt_ff < HDR_LEN;
      byte_bad  = (hdr_cnt_ff < MAGIC_LEN) && (req_data_byte != magic_byte(hdr_cnt_ff[1:0]));
      hdr_after = in_header ? hdr_cnt_ff + 4'd1 : hdr_cnt_ff;
      lane_full = hdr_cnt_ff - MAGIC_LEN;

      push_tok.data      = req_data_byte;
      push_tok.eof       = req_end_of_frame;
      push_tok.lane      = lane_full[2:0];
      push_tok.hdr_short = hdr_after < HDR_LEN;
      push_tok.magic_bad = 1'b0;
      if (!in_header) begin
         push_tok.kind = KIND_DIGIT;
      end else if (hdr_cnt_ff < MAGIC_LEN) begin
         push_tok.kind = KIND_MAGIC;
      end else begin
         push_tok.kind = KIND_TIME;
      end
      // mismatch is reported once the whole header is in
      if (in_header && (hdr_after == HDR_LEN)) begin
         push_tok.magic_bad = mism_ff || byte_bad;
      end

      hdr_cnt_in = hdr_cnt_ff;
      mism_in    = mism_ff;
      if (accept) begin
         if (req_end_of_frame) begin
            hdr_cnt_in = 4'd0;
            mism_in    = 1'b0;
         end else begin
            hdr_cnt_in = hdr_after;
            mism_in    = mism_ff || byte_bad;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hdr_cnt_ff <= 4'd0;
         mism_ff    <= 1'b0;
      end else begin
         hdr_cnt_ff <= hdr_cnt_in;
         mism_ff    <= mism_in;
      end
   end

endmodule

/* rtl/core/aer_queue.sv */
// short request queue between front and back ends
`include "aer_frame_decoder_assert.svh"

module aer_queue (
   input  logic             clock,
   input  logic             reset,
   input  logic             push_valid,
   input  aer_pkg::tok_type push_tok,
   output logic             full,
   output logic             pop_valid,
   input  logic             pop_ready,
   output aer_pkg::tok_type pop_tok
);
   import aer_pkg::*;

   tok_type             mem_ff [QUEUE_DEPTH];
   logic [QUEUE_AW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_AW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_AW:0]   cnt_ff, cnt_in;
   logic                push, pop;

   assign full      = cnt_ff == (QUEUE_AW+1)'(QUEUE_DEPTH);
   assign pop_valid = cnt_ff != '0;
   assign pop_tok   = mem_ff[rd_ptr_ff];
   assign push      = push_valid && !full;
   assign pop       = pop_valid && pop_ready;

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      cnt_in    = cnt_ff;
      if (push && !pop) begin
         cnt_in = cnt_ff + 1'b1;
      end else if (pop && !push) begin
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_tok;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   `AER_ASSERT_IMPLY(a_no_push_when_full, clock, reset, push_valid, !full)

endmodule

/* rtl/core/aer_back.sv */
// back end: varint decode, timestamp accumulation, status and response register
`include "aer_frame_decoder_assert.svh"

module aer_back (
   input  logic             clock,
   input  logic             reset,
   input  logic             pop_valid,
   output logic             pop_ready,
   input  aer_pkg::tok_type pop_tok,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output logic             rsp_event_valid,
   output logic [63:0]      rsp_event_time,
   output logic [31:0]      rsp_event_address,
   output logic [7:0]       rsp_event_value,
   output logic             rsp_frame_done,
   output logic [2:0]       rsp_frame_status
);
   import aer_pkg::*;

   logic [63:0] run_time_ff, run_time_in;
   logic [63:0] acc_ff, acc_in;
   logic [3:0]  digit_ff, digit_in;
   logic [1:0]  field_ff, field_in;
   logic [31:0] addr_ff, addr_in;
   logic [2:0]  err_ff, err_in;

   logic        rsp_valid_ff;
   logic        rsp_event_valid_ff;
   logic [63:0] rsp_event_time_ff;
   logic [31:0] rsp_event_address_ff;
   logic [7:0]  rsp_event_value_ff;
   logic        rsp_frame_done_ff;
   logic [2:0]  rsp_frame_status_ff;

   logic        ev;
   logic [63:0] ev_time;
   logic [31:0] ev_addr;
   logic [7:0]  ev_val;
   logic [2:0]  status;
   logic [6:0]  dig_shift;
   logic [63:0] dig_part;
   logic [63:0] acc_new;
   logic [3:0]  digit_inc;
   logic        has_rsp;
   logic        slot_free;
   logic        step;

   always_comb begin
      run_time_in = run_time_ff;
      acc_in      = acc_ff;
      digit_in    = digit_ff;
      field_in    = field_ff;
      addr_in     = addr_ff;
      err_in      = err_ff;
      ev          = 1'b0;
      ev_time     = 64'd0;
      ev_addr     = 32'd0;
      ev_val      = 8'd0;

      // digit position times seven; only bit zero survives at the top digit
      dig_shift = ({3'd0, digit_ff} << 3) - {3'd0, digit_ff};
      dig_part  = dig_shift[6] ? 64'd0 : ({57'd0, pop_tok.data[6:0]} << dig_shift[5:0]);
      acc_new   = acc_ff | dig_part;
      digit_inc = digit_ff + 4'd1;

      if (err_ff == ST_OK) begin
         case (pop_tok.kind)
            KIND_MAGIC: begin
               if (pop_tok.magic_bad) begin
                  err_in = ST_MAGIC;
               end
            end
            KIND_TIME: begin
               run_time_in = run_time_ff | ({56'd0, pop_tok.data} << {pop_tok.lane, 3'b000});
               if (pop_tok.magic_bad) begin
                  err_in = ST_MAGIC;
               end
            end
            KIND_DIGIT: begin
               if (!pop_tok.data[7]) begin
                  case (field_ff)
                     FIELD_DELTA: begin
                        run_time_in = run_time_ff + acc_new;
                        field_in    = FIELD_ADDRESS;
                     end
                     FIELD_ADDRESS: begin
                        addr_in  = acc_new[31:0];
                        field_in = FIELD_VALUE;
                     end
                     default: begin
                        ev       = 1'b1;
                        ev_time  = run_time_ff;
                        ev_addr  = addr_ff;
                        ev_val   = acc_new[7:0];
                        field_in = FIELD_DELTA;
                     end
                  endcase
                  acc_in   = 64'd0;
                  digit_in = 4'd0;
               end else begin
                  acc_in   = acc_new;
                  digit_in = digit_inc;
                  if (digit_inc >= DIGIT_LIMIT) begin
                     err_in = ST_OVERFLOW;
                  end
               end
            end
            default: begin
            end
         endcase
      end

      if (err_in != ST_OK) begin
         status = err_in;
      end else if (pop_tok.hdr_short) begin
         status = ST_SHORT;
      end else if ((digit_in != 4'd0) || (field_in != FIELD_DELTA)) begin
         status = ST_TRUNC;
      end else begin
         status = ST_OK;
      end

      // a request that needs no response slot never waits on the output
      has_rsp   = ev || pop_tok.eof;
      slot_free = !rsp_valid_ff || rsp_ready;
      pop_ready = !has_rsp || slot_free;
      step      = pop_valid && pop_ready;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_time_ff <= 64'd0;
         acc_ff      <= 64'd0;
         digit_ff    <= 4'd0;
         field_ff    <= FIELD_DELTA;
         addr_ff     <= 32'd0;
         err_ff      <= ST_OK;
      end else if (step) begin
         if (pop_tok.eof) begin
            run_time_ff <= 64'd0;
            acc_ff      <= 64'd0;
            digit_ff    <= 4'd0;
            field_ff    <= FIELD_DELTA;
            addr_ff     <= 32'd0;
            err_ff      <= ST_OK;
         end else begin
            run_time_ff <= run_time_in;
            acc_ff      <= acc_in;
            digit_ff    <= digit_in;
            field_ff    <= field_in;
            addr_ff     <= addr_in;
            err_ff      <= err_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (step && has_rsp) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (step && has_rsp) begin
         rsp_event_valid_ff   <= ev;
         rsp_event_time_ff    <= ev_time;
         rsp_event_address_ff <= ev_addr;
         rsp_event_value_ff   <= ev_val;
         rsp_frame_done_ff    <= pop_tok.eof;
         rsp_frame_status_ff  <= pop_tok.eof ? status : ST_OK;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_event_valid   = rsp_event_valid_ff;
   assign rsp_event_time    = rsp_event_time_ff;
   assign rsp_event_address = rsp_event_address_ff;
   assign rsp_event_value   = rsp_event_value_ff;
   assign rsp_frame_done    = rsp_frame_done_ff;
   assign rsp_frame_status  = rsp_frame_status_ff;

   `AER_ASSERT_IMPLY(a_rsp_has_content, clock, reset, rsp_valid_ff, rsp_event_valid_ff || rsp_frame_done_ff)
   `AER_ASSERT_IMPLY(a_status_needs_done, clock, reset, rsp_valid_ff && !rsp_frame_done_ff, rsp_frame_status_ff == ST_OK)
   `AER_ASSERT_IMPLY(a_no_event_after_error, clock, reset, step && (err_ff != ST_OK), !ev)
   `AER_ASSERT_NEXT(a_error_sticky, clock, reset, (err_ff != ST_OK) && !(step && pop_tok.eof), err_ff == $past(err_ff))

endmodule

/* rtl/core/aer_frame_decoder.sv */
// top level of the aer frame decoder
// path: a taken request is written into the queue, then passes the back end response
//   register; rsp_ready back-pressure can hold it in the queue before it is valid
// throughput: one byte per cycle while the queue has room; the varint merge and 64-bit
//   timestamp add are combinational; a four-entry queue decouples the front end
// reset: synchronous, clears all frame state, the queue and the response valid flag
module aer_frame_decoder (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_data_byte,
   input  logic        req_end_of_frame,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic        rsp_event_valid,
   output logic [63:0] rsp_event_time,
   output logic [31:0] rsp_event_address,
   output logic [7:0]  rsp_event_value,
   output logic        rsp_frame_done,
   output logic [2:0]  rsp_frame_status
);
   import aer_pkg::*;

   tok_type push_tok;
   tok_type pop_tok;
   logic    push_valid;
   logic    queue_full;
   logic    pop_valid;
   logic    pop_ready;

   aer_front u_front (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_data_byte    (req_data_byte),
      .req_end_of_frame (req_end_of_frame),
      .queue_full       (queue_full),
      .push_valid       (push_valid),
      .push_tok         (push_tok)
   );

   aer_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_tok   (push_tok),
      .full       (queue_full),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_tok    (pop_tok)
   );

   aer_back u_back (
      .clock             (clock),
      .reset             (reset),
      .pop_valid         (pop_valid),
      .pop_ready         (pop_ready),
      .pop_tok           (pop_tok),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_event_valid   (rsp_event_valid),
      .rsp_event_time    (rsp_event_time),
      .rsp_event_address (rsp_event_address),
      .rsp_event_value   (rsp_event_value),
      .rsp_frame_done    (rsp_frame_done),
      .rsp_frame_status  (rsp_frame_status)
   );

endmodule
